// ===== design/hermitian_band_matvec_core_macros.svh =====
// assertion macros for the hermitian band matrix-vector core
`ifndef HERMITIAN_BAND_MATVEC_CORE_MACROS_SVH
`define HERMITIAN_BAND_MATVEC_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define HBMV_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hbmv assertion failed");

// next-cycle implication, disabled during reset
`define HBMV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hbmv assertion failed");

`endif

// ===== design/hbmv_pkg.sv =====
// shared constants, types and saturation helpers for the band matvec core
`timescale 1ns / 1ps
`default_nettype none

package hbmv_pkg;

   localparam int N_MAX      = 64;
   localparam int K_MAX      = 8;
   localparam int BAND_ROWS  = K_MAX + 1;
   localparam int BAND_DEPTH = N_MAX * BAND_ROWS;
   localparam int IDX_W      = $clog2(N_MAX);
   localparam int CNT_W      = IDX_W + 1;
   localparam int ROW_W      = 4;
   localparam int BAND_AW    = $clog2(BAND_DEPTH);
   localparam int DATA_W     = 32;
   localparam int PROD_W     = 48;
   localparam int ACC_W      = PROD_W + 1;
   localparam int CSR_IDX_W  = 3;

   localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CFG_LOWER    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_LENGTH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CFG_BAND     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CFG_ALPHA_RE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CFG_ALPHA_IM = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CFG_BETA_RE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CFG_BETA_IM  = 3'd6;

   // request modes
   localparam logic [1:0] MODE_LOAD_X    = 2'd0;
   localparam logic [1:0] MODE_LOAD_Y    = 2'd1;
   localparam logic [1:0] MODE_LOAD_BAND = 2'd2;
   localparam logic [1:0] MODE_RUN       = 2'd3;

   typedef struct packed {
      logic signed [DATA_W-1:0] re;
      logic signed [DATA_W-1:0] im;
   } cval_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                     valid;
      logic [IDX_W-1:0]         index;
      logic signed [DATA_W-1:0] re;
      logic signed [DATA_W-1:0] im;
      logic                     last;
   } emit_type;

   function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = 49'sd2147483647;
      lo = -49'sd2147483648;
      if (v > hi) begin
         return 32'sh7fff_ffff;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[DATA_W-1:0];
   endfunction

   function automatic cval_type cadd(input cval_type a, input cval_type b);
      cval_type r;
      r.re = sat_wide(ACC_W'(a.re) + ACC_W'(b.re));
      r.im = sat_wide(ACC_W'(a.im) + ACC_W'(b.im));
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/hbmv_if.sv =====
// valid/ready channel interfaces for requests and responses
`timescale 1ns / 1ps
`default_nettype none

interface hbmv_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [5:0]         row_slot;
   logic [5:0]         column;
   logic signed [31:0] value_re;
   logic signed [31:0] value_im;
   modport source (output valid, mode, row_slot, column, value_re, value_im, input ready);
   modport sink   (input valid, mode, row_slot, column, value_re, value_im, output ready);
endinterface

interface hbmv_rsp_if;
   logic               valid;
   logic               ready;
   logic [5:0]         out_index;
   logic signed [31:0] out_re;
   logic signed [31:0] out_im;
   logic               last;
   modport source (output valid, out_index, out_re, out_im, last, input ready);
   modport sink   (input valid, out_index, out_re, out_im, last, output ready);
endinterface

`default_nettype wire

// ===== design/hbmv_mul.sv =====
// shared signed 32x32 multiplier with q16 floor scaling and registered product
`timescale 1ns / 1ps
`default_nettype none

module hbmv_mul
   import hbmv_pkg::*;
(
   input  wire logic                     clock,
   input  wire mul_req_type              mul_req,
   output logic signed [PROD_W-1:0]      mul_prod
);

   logic signed [2*DATA_W-1:0] full;
   logic signed [PROD_W-1:0]   prod_ff;

   assign full = (2*DATA_W)'(mul_req.a) * (2*DATA_W)'(mul_req.b);

   // dropping the low 16 bits rounds toward minus infinity
   always_ff @(posedge clock) begin
      prod_ff <= full[2*DATA_W-1:16];
   end

   assign mul_prod = prod_ff;

endmodule

`default_nettype wire

// ===== design/hbmv_seq.sv =====
// sequencer, vector and band stores, configuration registers
`timescale 1ns / 1ps
`default_nettype none

module hbmv_seq
   import hbmv_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   hbmv_req_if.sink                   req_bus,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [DATA_W-1:0]     csr_wdata,
   output mul_req_type                mul_req,
   input  wire logic signed [PROD_W-1:0] mul_prod,
   output emit_type                   emit,
   input  wire logic                  emit_take
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_B_RD  = 5'd1;
   localparam logic [4:0] S_B_MUL = 5'd2;
   localparam logic [4:0] S_B_WR  = 5'd3;
   localparam logic [4:0] S_ALPHA = 5'd4;
   localparam logic [4:0] S_C_RD  = 5'd5;
   localparam logic [4:0] S_C_T1  = 5'd6;
   localparam logic [4:0] S_C_SET = 5'd7;
   localparam logic [4:0] S_I_CHK = 5'd8;
   localparam logic [4:0] S_I_RD  = 5'd9;
   localparam logic [4:0] S_I_M1  = 5'd10;
   localparam logic [4:0] S_I_M2  = 5'd11;
   localparam logic [4:0] S_I_M3  = 5'd12;
   localparam logic [4:0] S_D_RD  = 5'd13;
   localparam logic [4:0] S_D_M1  = 5'd14;
   localparam logic [4:0] S_D_M2  = 5'd15;
   localparam logic [4:0] S_D_M3  = 5'd16;
   localparam logic [4:0] S_F_RD  = 5'd17;
   localparam logic [4:0] S_F_M1  = 5'd18;
   localparam logic [4:0] S_F_M2  = 5'd19;
   localparam logic [4:0] S_J_NXT = 5'd20;
   localparam logic [4:0] S_E_RD  = 5'd21;
   localparam logic [4:0] S_E_LD  = 5'd22;
   localparam logic [4:0] S_MUL   = 5'd23;

   // stores
   cval_type x_mem    [N_MAX];
   cval_type y_mem    [N_MAX];
   cval_type band_mem [BAND_DEPTH];

   cval_type x_rd_ff, y_rd_ff, band_rd_ff;

   logic               x_we, y_we, band_we;
   logic [IDX_W-1:0]   x_waddr, y_waddr, x_raddr, y_raddr;
   logic [BAND_AW-1:0] band_waddr, band_raddr;
   cval_type           y_wdata, ld_value;

   // configuration
   logic                     lower_ff;
   logic [6:0]               vlen_ff;
   logic [3:0]               bw_ff;
   logic signed [DATA_W-1:0] alpha_re_ff, alpha_im_ff, beta_re_ff, beta_im_ff;

   // sequencer state
   logic [4:0]        state_ff, state_in, ret_ff, ret_in;
   logic [2:0]        mstep_ff, mstep_in;
   logic [CNT_W-1:0]  i_ff, i_in, i_end_ff, i_end_in, n_ff, n_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [ROW_W-1:0]  k_ff, k_in;
   cval_type          t1_ff, t1_in, t2_ff, t2_in, a_ff, a_in, xi_ff, xi_in;
   cval_type          yi_ff, yi_in, tmp_ff, tmp_in, prod_ff, prod_in;
   cval_type          op_a_ff, op_a_in, op_b_ff, op_b_in;
   logic              conj_ff, conj_in;
   logic signed [ACC_W-1:0] acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;

   cval_type               alpha, beta;
   logic                   req_fire, beta_one, beta_zero, alpha_zero;
   logic [CNT_W-1:0]       j_ext, k_ext, i_next, lo_end;
   logic [7:0]             inner_row_w;
   logic [ROW_W-1:0]       row_sel;
   logic signed [ACC_W-1:0] p_ext;

   assign alpha      = '{re: alpha_re_ff, im: alpha_im_ff};
   assign beta       = '{re: beta_re_ff, im: beta_im_ff};
   assign beta_one   = (beta_re_ff == Q_ONE) && (beta_im_ff == '0);
   assign beta_zero  = (beta_re_ff == '0) && (beta_im_ff == '0);
   assign alpha_zero = (alpha_re_ff == '0) && (alpha_im_ff == '0);
   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire   = req_bus.valid && req_bus.ready;
   assign ld_value   = '{re: req_bus.value_re, im: req_bus.value_im};
   assign j_ext      = CNT_W'(j_ff);
   assign k_ext      = CNT_W'(k_ff);
   assign i_next     = i_ff + CNT_W'(1);
   assign lo_end     = ((j_ext + k_ext + CNT_W'(1)) < n_ff) ? (j_ext + k_ext + CNT_W'(1)) : n_ff;
   assign p_ext      = ACC_W'(mul_prod);

   // band row of an off-diagonal entry, or the diagonal row
   assign inner_row_w = lower_ff ? (8'(i_ff) - 8'(j_ff)) : (8'(k_ff) + 8'(i_ff) - 8'(j_ff));
   assign row_sel     = (state_ff == S_D_RD) ? (lower_ff ? '0 : k_ff) : inner_row_w[ROW_W-1:0];

   assign x_raddr    = (state_ff == S_C_RD) ? j_ff : i_ff[IDX_W-1:0];
   assign y_raddr    = ((state_ff == S_D_RD) || (state_ff == S_F_RD)) ? j_ff : i_ff[IDX_W-1:0];
   assign band_raddr = BAND_AW'(j_ff) * BAND_AW'(BAND_ROWS) + BAND_AW'(row_sel);

   assign x_we       = req_fire && (req_bus.mode == MODE_LOAD_X);
   assign x_waddr    = req_bus.row_slot;
   assign band_we    = req_fire && (req_bus.mode == MODE_LOAD_BAND)
                       && (req_bus.row_slot <= IDX_W'(K_MAX));
   assign band_waddr = BAND_AW'(req_bus.column) * BAND_AW'(BAND_ROWS)
                       + BAND_AW'(req_bus.row_slot);

   // operand pairs for the four partial products
   always_comb begin
      case (mstep_ff)
         3'd0:    mul_req = '{a: op_a_ff.re, b: op_b_ff.re};
         3'd1:    mul_req = '{a: op_a_ff.im, b: op_b_ff.im};
         3'd2:    mul_req = '{a: op_a_ff.re, b: op_b_ff.im};
         3'd3:    mul_req = '{a: op_a_ff.im, b: op_b_ff.re};
         default: mul_req = '{a: op_a_ff.re, b: op_b_ff.re};
      endcase
   end

   always_comb begin
      emit.valid = (state_ff == S_E_LD);
      emit.index = i_ff[IDX_W-1:0];
      emit.re    = y_rd_ff.re;
      emit.im    = y_rd_ff.im;
      emit.last  = (i_next == n_ff);
   end

   always_comb begin
      state_in  = state_ff;   ret_in   = ret_ff;   mstep_in = mstep_ff;
      i_in      = i_ff;       i_end_in = i_end_ff; n_in     = n_ff;
      j_in      = j_ff;       k_in     = k_ff;
      t1_in     = t1_ff;      t2_in    = t2_ff;    a_in     = a_ff;
      xi_in     = xi_ff;      yi_in    = yi_ff;    tmp_in   = tmp_ff;
      prod_in   = prod_ff;    op_a_in  = op_a_ff;  op_b_in  = op_b_ff;
      conj_in   = conj_ff;    acc_re_in = acc_re_ff; acc_im_in = acc_im_ff;
      y_we      = 1'b0;
      y_waddr   = i_ff[IDX_W-1:0];
      y_wdata   = prod_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_bus.mode == MODE_LOAD_Y)) begin
               y_we    = 1'b1;
               y_waddr = req_bus.row_slot;
               y_wdata = ld_value;
            end
            if (req_fire && (req_bus.mode == MODE_RUN)) begin
               n_in = (vlen_ff > 7'(N_MAX)) ? CNT_W'(N_MAX) : CNT_W'(vlen_ff);
               k_in = (bw_ff > ROW_W'(K_MAX)) ? ROW_W'(K_MAX) : bw_ff;
               i_in = '0;
               if (vlen_ff != '0) begin
                  state_in = beta_one ? S_ALPHA : S_B_RD;
               end
            end
         end
         S_B_RD: state_in = S_B_MUL;
         S_B_MUL: begin
            if (beta_zero) begin
               y_we     = 1'b1;
               y_wdata  = '0;
               i_in     = i_next;
               state_in = (i_next == n_ff) ? S_ALPHA : S_B_RD;
            end else begin
               op_a_in = beta; op_b_in = y_rd_ff; conj_in = 1'b0;
               mstep_in = '0; ret_in = S_B_WR; state_in = S_MUL;
            end
         end
         S_B_WR: begin
            y_we     = 1'b1;
            i_in     = i_next;
            state_in = (i_next == n_ff) ? S_ALPHA : S_B_RD;
         end
         S_ALPHA: begin
            i_in     = '0;
            j_in     = '0;
            state_in = alpha_zero ? S_E_RD : S_C_RD;
         end
         S_C_RD: state_in = S_C_T1;
         S_C_T1: begin
            op_a_in = alpha; op_b_in = x_rd_ff; conj_in = 1'b0;
            mstep_in = '0; ret_in = S_C_SET; state_in = S_MUL;
         end
         S_C_SET: begin
            t1_in = prod_ff;
            t2_in = '0;
            if (lower_ff) begin
               i_in     = j_ext + CNT_W'(1);
               i_end_in = lo_end;
               state_in = S_D_RD;
            end else begin
               i_in     = (j_ext > k_ext) ? (j_ext - k_ext) : '0;
               i_end_in = j_ext;
               state_in = S_I_CHK;
            end
         end
         S_I_CHK: begin
            if (i_ff < i_end_ff) begin
               state_in = S_I_RD;
            end else begin
               state_in = lower_ff ? S_F_RD : S_D_RD;
            end
         end
         S_I_RD: state_in = S_I_M1;
         S_I_M1: begin
            a_in = band_rd_ff; xi_in = x_rd_ff; yi_in = y_rd_ff;
            op_a_in = t1_ff; op_b_in = band_rd_ff; conj_in = 1'b0;
            mstep_in = '0; ret_in = S_I_M2; state_in = S_MUL;
         end
         S_I_M2: begin
            y_we    = 1'b1;
            y_wdata = cadd(yi_ff, prod_ff);
            op_a_in = a_ff; op_b_in = xi_ff; conj_in = 1'b1;
            mstep_in = '0; ret_in = S_I_M3; state_in = S_MUL;
         end
         S_I_M3: begin
            t2_in    = cadd(t2_ff, prod_ff);
            i_in     = i_next;
            state_in = S_I_CHK;
         end
         S_D_RD: state_in = S_D_M1;
         S_D_M1: begin
            yi_in   = y_rd_ff;
            op_a_in = t1_ff;
            op_b_in = '{re: band_rd_ff.re, im: '0};
            conj_in = 1'b0;
            mstep_in = '0; ret_in = S_D_M2; state_in = S_MUL;
         end
         S_D_M2: begin
            if (lower_ff) begin
               y_we     = 1'b1;
               y_waddr  = j_ff;
               y_wdata  = cadd(yi_ff, prod_ff);
               state_in = S_I_CHK;
            end else begin
               tmp_in  = prod_ff;
               op_a_in = alpha; op_b_in = t2_ff; conj_in = 1'b0;
               mstep_in = '0; ret_in = S_D_M3; state_in = S_MUL;
            end
         end
         S_D_M3: begin
            y_we     = 1'b1;
            y_waddr  = j_ff;
            y_wdata  = cadd(yi_ff, cadd(tmp_ff, prod_ff));
            state_in = S_J_NXT;
         end
         S_F_RD: state_in = S_F_M1;
         S_F_M1: begin
            yi_in   = y_rd_ff;
            op_a_in = alpha; op_b_in = t2_ff; conj_in = 1'b0;
            mstep_in = '0; ret_in = S_F_M2; state_in = S_MUL;
         end
         S_F_M2: begin
            y_we     = 1'b1;
            y_waddr  = j_ff;
            y_wdata  = cadd(yi_ff, prod_ff);
            state_in = S_J_NXT;
         end
         S_J_NXT: begin
            if ((j_ext + CNT_W'(1)) == n_ff) begin
               i_in     = '0;
               state_in = S_E_RD;
            end else begin
               j_in     = j_ff + IDX_W'(1);
               state_in = S_C_RD;
            end
         end
         S_E_RD: state_in = S_E_LD;
         S_E_LD: begin
            if (emit_take) begin
               i_in     = i_next;
               state_in = (i_next == n_ff) ? S_IDLE : S_E_RD;
            end
         end
         S_MUL: begin
            mstep_in = mstep_ff + 3'd1;
            case (mstep_ff)
               3'd1: acc_re_in = p_ext;
               3'd2: acc_re_in = conj_ff ? (acc_re_ff + p_ext) : (acc_re_ff - p_ext);
               3'd3: acc_im_in = p_ext;
               3'd4: begin
                  prod_in.re = sat_wide(acc_re_ff);
                  prod_in.im = sat_wide(conj_ff ? (acc_im_ff - p_ext) : (acc_im_ff + p_ext));
                  mstep_in   = '0;
                  state_in   = ret_ff;
               end
               default: ;
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         mstep_ff    <= '0;
         lower_ff    <= 1'b0;
         vlen_ff     <= '0;
         bw_ff       <= '0;
         alpha_re_ff <= Q_ONE;
         alpha_im_ff <= '0;
         beta_re_ff  <= '0;
         beta_im_ff  <= '0;
      end else begin
         state_ff <= state_in;
         mstep_ff <= mstep_in;
         if (csr_we) begin
            case (csr_index)
               CFG_LOWER:    lower_ff    <= csr_wdata[0];
               CFG_LENGTH:   vlen_ff     <= csr_wdata[6:0];
               CFG_BAND:     bw_ff       <= csr_wdata[3:0];
               CFG_ALPHA_RE: alpha_re_ff <= csr_wdata;
               CFG_ALPHA_IM: alpha_im_ff <= csr_wdata;
               CFG_BETA_RE:  beta_re_ff  <= csr_wdata;
               CFG_BETA_IM:  beta_im_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ret_ff    <= ret_in;    i_ff     <= i_in;     i_end_ff <= i_end_in;
      n_ff      <= n_in;      j_ff     <= j_in;     k_ff     <= k_in;
      t1_ff     <= t1_in;     t2_ff    <= t2_in;    a_ff     <= a_in;
      xi_ff     <= xi_in;     yi_ff    <= yi_in;    tmp_ff   <= tmp_in;
      prod_ff   <= prod_in;   op_a_ff  <= op_a_in;  op_b_ff  <= op_b_in;
      conj_ff   <= conj_in;   acc_re_ff <= acc_re_in; acc_im_ff <= acc_im_in;
   end

   always_ff @(posedge clock) begin
      if (x_we) begin
         x_mem[x_waddr] <= ld_value;
      end
      if (y_we) begin
         y_mem[y_waddr] <= y_wdata;
      end
      if (band_we) begin
         band_mem[band_waddr] <= ld_value;
      end
   end

   always_ff @(posedge clock) begin
      x_rd_ff    <= x_mem[x_raddr];
      y_rd_ff    <= y_mem[y_raddr];
      band_rd_ff <= band_mem[band_raddr];
   end

endmodule

`default_nettype wire

// ===== design/hermitian_band_matvec_core.sv =====
// top level of the hermitian band matrix-vector core with response register
// usage:
//   req_bus carries load and run items; a transfer happens when valid and ready are high.
//   mode 0/1 load x/y at row_slot, mode 2 loads a band entry (row_slot, column),
//   mode 3 runs y := alpha*A*x + beta*y and streams n results on rsp_bus.
//   csr_we/csr_index/csr_wdata write the seven registers; the user must do so only
//   while the core is idle, as the core does not check it.
// timing:
//   loads can transfer back to back. a run is walked by a sequencer around one shared
//   32x32 multiplier; every complex product is four passes through it.
//   a run makes a beta pass over y (skipped for beta one, a plain clear for beta zero),
//   a pass over the columns and a stream-out; req_bus.ready is low for the whole run.
//   results leave through an output register; the sequencer reads the next result
//   while the register still holds an earlier result.
// reset:
//   synchronous, active high; alpha = 1.0, beta = 0, n = k = 0; stores hold
//   garbage until written.
// stalls:
//   if rsp_bus.ready is low the result register holds and the sequencer waits
//   on the next element; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none
`include "hermitian_band_matvec_core_macros.svh"

module hermitian_band_matvec_core
   import hbmv_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   hbmv_req_if.sink                  req_bus,
   hbmv_rsp_if.source                rsp_bus,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]    csr_wdata
);

   mul_req_type              mul_req;
   logic signed [PROD_W-1:0] mul_prod;
   emit_type                 emit;
   logic                     emit_take;

   // response register
   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         rsp_index_ff;
   logic signed [DATA_W-1:0] rsp_re_ff, rsp_im_ff;
   logic                     rsp_last_ff;

   hbmv_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mul_req   (mul_req),
      .mul_prod  (mul_prod),
      .emit      (emit),
      .emit_take (emit_take)
   );

   hbmv_mul u_mul (
      .clock    (clock),
      .mul_req  (mul_req),
      .mul_prod (mul_prod)
   );

   // slot is free when empty or being drained this cycle
   assign emit_take = !rsp_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.valid && emit_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid && emit_take) begin
         rsp_index_ff <= emit.index;
         rsp_re_ff    <= emit.re;
         rsp_im_ff    <= emit.im;
         rsp_last_ff  <= emit.last;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_index = rsp_index_ff;
   assign rsp_bus.out_re    = rsp_re_ff;
   assign rsp_bus.out_im    = rsp_im_ff;
   assign rsp_bus.last      = rsp_last_ff;

   // loads are only taken while nothing is being emitted
   `HBMV_ASSERT_NOW(a_idle_no_emit, clock, reset, req_bus.ready, !emit.valid)
   // an emitted element lands in the response register
   `HBMV_ASSERT_NEXT(a_emit_lands, clock, reset, emit.valid && emit_take, rsp_valid_ff)
   // after the final element the core is idle again
   `HBMV_ASSERT_NEXT(a_last_idle, clock, reset, emit.valid && emit_take && emit.last,
                     req_bus.ready && rsp_last_ff)

endmodule

`default_nettype wire
